>>> hw/rtl/fra_pkg.sv
// fra_pkg: shared types and constants for the fisheye remap address block.
// Register indexes, register reset values and the CORDIC angle table.
// No dependencies.
package fra_pkg;

	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 3;
	localparam int CORDIC_N = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X = 3'd0,
		REG_FOCAL_Y = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_COEF_T2 = 3'd4,
		REG_COEF_T4 = 3'd5,
		REG_COEF_T6 = 3'd6,
		REG_COEF_T8 = 3'd7
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] FOCAL_X_RST  = 20'd81920;
	localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 20'd81920;
	localparam logic [CFG_W-1:0] CENTER_X_RST = 20'd81920;
	localparam logic [CFG_W-1:0] CENTER_Y_RST = 20'd61440;

	// round(atan(2^-i) * 65536)
	localparam logic [16:0] ATAN_TAB [CORDIC_N] = '{
		17'd51472, 17'd30385, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
		17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2
	};

endpackage

>>> hw/rtl/fra_pipe_div.sv
// fra_pipe_div: pipelined restoring divider, one quotient bit per stage.
// One word per cycle, frozen while en is low.
// No dependencies.
module fra_pipe_div #(
	parameter int QW = 31,
	parameter int DW = 20
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem_in,  // starting partial remainder, below dvs_in
	input  logic [QW-1:0] dvd_in,  // dividend bits shifted in, MSB first
	input  logic [DW-1:0] dvs_in,
	output logic [QW-1:0] quo
);

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [QW-1:0] dvd;
		logic [QW-1:0] quo;
		logic [DW-1:0] dvs;
	} dv_t;

	function automatic dv_t dv_step(dv_t a);
		dv_t b;
		logic [DW:0] r2;
		logic [DW:0] diff;
		logic ge;
		r2 = {a.rem, a.dvd[QW-1]};
		diff = r2 - {1'b0, a.dvs};
		ge = (r2 >= {1'b0, a.dvs});
		b.rem = ge ? diff[DW-1:0] : r2[DW-1:0];
		b.dvd = a.dvd << 1;
		b.quo = {a.quo[QW-2:0], ge};
		b.dvs = a.dvs;
		return b;
	endfunction

	dv_t st_in;
	dv_t st_s [1:QW];

	assign st_in = '{rem: rem_in, dvd: dvd_in, quo: '0, dvs: dvs_in};

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[1] <= dv_step(st_in);
			for (int k = 2; k <= QW; k++) begin
				st_s[k] <= dv_step(st_s[k-1]);
			end
		end
	end

	assign quo = st_s[QW].quo;

endmodule

>>> hw/rtl/fisheye_remap_address.sv
// fisheye_remap_address: equidistant fisheye remap address generator.
// Uses fra_pkg and fra_pipe_div (normalize and direction divides).
//
//   channel   dir  signals                         word
//   s_axis    in   tvalid tready tdata[23:0]       pixel_x, pixel_y
//   m_axis    out  tvalid tready tdata[23:0] tuser source_x, source_y / remapped
//   cfg       in   cfg_we cfg_index cfg_wdata      register writes
//
// One word per cycle unless a held output word stalls the pipeline, which
// includes the 31-stage normalize divider and the 32-stage square root.
// The whole pipeline moves on one enable; a held output word freezes all
// stages, so s_axis_tready follows m_axis_tready when the output is full.
// Reset clears the valid bits and loads the register defaults.
module fisheye_remap_address
	import fra_pkg::*;
#(
	parameter int IMAGE_WIDTH  = 640,
	parameter int IMAGE_HEIGHT = 480
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,   // pixel_x[9:0], pixel_y[18:10], zero
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,   // source_x[9:0], source_y[18:10], zero
	output logic                 m_axis_tuser,   // remapped
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int NDIV_QW = 31;
	localparam int UDIV_QW = 17;
	localparam int SQ_N    = 32;
	localparam int S_MAG   = 2;
	localparam int S_NQ    = S_MAG + NDIV_QW;
	localparam int S_NM    = S_NQ + 1;
	localparam int S_SUM   = S_NM + 2;
	localparam int S_R     = S_SUM + SQ_N;
	localparam int S_TH    = S_R + CORDIC_N + 1;
	localparam int S_UQ    = S_R + UDIV_QW;
	localparam int S_POLY  = S_TH + 6;
	localparam int S_THD   = S_POLY + 1;
	localparam int S_M     = S_THD + 1;
	localparam int S_OUT   = S_M + 3;

	typedef struct packed {
		logic [9:0] px;
		logic [8:0] py;
		logic       neg_x;
		logic       neg_y;
		logic       sat_x;
		logic       sat_y;
	} side_t;

	typedef struct packed {
		logic [63:0] val;
		logic [33:0] rem;
		logic [31:0] root;
	} sq_t;

	typedef struct packed {
		logic signed [35:0] x;
		logic signed [35:0] y;
		logic signed [19:0] z;
	} cd_t;

	function automatic sq_t sq_step(sq_t a);
		sq_t b;
		logic [35:0] rr;
		logic [35:0] trial;
		logic [35:0] diff;
		logic ge;
		rr = {a.rem, a.val[63:62]};
		trial = {2'b00, a.root, 2'b01};
		diff = rr - trial;
		ge = (rr >= trial);
		b.rem = ge ? diff[33:0] : rr[33:0];
		b.root = {a.root[30:0], ge};
		b.val = a.val << 2;
		return b;
	endfunction

	function automatic cd_t cd_step(cd_t a, logic [3:0] i);
		cd_t b;
		logic signed [19:0] ang;
		ang = $signed({3'b000, ATAN_TAB[i]});
		if (!a.y[35]) begin
			b.x = a.x + (a.y >>> i);
			b.y = a.y - (a.x >>> i);
			b.z = a.z + ang;
		end else begin
			b.x = a.x - (a.y >>> i);
			b.y = a.y + (a.x >>> i);
			b.z = a.z - ang;
		end
		return b;
	endfunction

	// configuration
	logic [CFG_W-1:0]        focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic signed [CFG_W-1:0] coef_t2_q, coef_t4_q, coef_t6_q, coef_t8_q;
	logic [CFG_W-1:0]        fx_eff, fy_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= FOCAL_X_RST;
			focal_y_q <= FOCAL_Y_RST;
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			coef_t2_q <= '0;
			coef_t4_q <= '0;
			coef_t6_q <= '0;
			coef_t8_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FOCAL_X: focal_x_q <= cfg_wdata;
				REG_FOCAL_Y: focal_y_q <= cfg_wdata;
				REG_CENTER_X: center_x_q <= cfg_wdata;
				REG_CENTER_Y: center_y_q <= cfg_wdata;
				REG_COEF_T2: coef_t2_q <= $signed(cfg_wdata);
				REG_COEF_T4: coef_t4_q <= $signed(cfg_wdata);
				REG_COEF_T6: coef_t6_q <= $signed(cfg_wdata);
				REG_COEF_T8: coef_t8_q <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	// a zero focal length behaves as one
	assign fx_eff = (focal_x_q == '0) ? 20'd1 : focal_x_q;
	assign fy_eff = (focal_y_q == '0) ? 20'd1 : focal_y_q;

	// pipeline control
	logic [S_OUT:1] vld_q;
	logic           en;

	assign en = !vld_q[S_OUT] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[S_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[S_OUT-1:1], s_axis_tvalid};
		end
	end

	// stages 1-2: offset from center, magnitude, saturation check
	logic [9:0]         in_px;
	logic [8:0]         in_py;
	logic signed [20:0] d_x_s1, d_y_s1;
	logic signed [20:0] nd_x, nd_y;
	logic [19:0]        mag_x_c, mag_y_c;
	logic [19:0]        mag_x_s2, mag_y_s2;
	side_t              side_s [1:S_OUT-1];
	side_t              side_in2;

	assign in_px = s_axis_tdata[9:0];
	assign in_py = s_axis_tdata[18:10];
	assign nd_x = -d_x_s1;
	assign nd_y = -d_y_s1;
	assign mag_x_c = d_x_s1[20] ? nd_x[19:0] : d_x_s1[19:0];
	assign mag_y_c = d_y_s1[20] ? nd_y[19:0] : d_y_s1[19:0];

	always_comb begin
		side_in2 = side_s[1];
		side_in2.neg_x = d_x_s1[20];
		side_in2.neg_y = d_y_s1[20];
		// quotient would reach 2^31: clamp
		side_in2.sat_x = ({15'd0, mag_x_c} >= {fx_eff, 15'd0});
		side_in2.sat_y = ({15'd0, mag_y_c} >= {fy_eff, 15'd0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_x_s1 <= $signed({3'b000, in_px, 8'h00}) - $signed({1'b0, center_x_q});
			d_y_s1 <= $signed({4'b0000, in_py, 8'h00}) - $signed({1'b0, center_y_q});
			side_s[1] <= '{px: in_px, py: in_py, neg_x: 1'b0, neg_y: 1'b0,
				sat_x: 1'b0, sat_y: 1'b0};
			mag_x_s2 <= mag_x_c;
			mag_y_s2 <= mag_y_c;
			side_s[2] <= side_in2;
			for (int k = 3; k <= S_OUT - 1; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// normalize: |d| * 65536 / focal
	logic [NDIV_QW-1:0] qn_x, qn_y;

	fra_pipe_div #(.QW(NDIV_QW), .DW(CFG_W)) u_div_nx (
		.clk(clk), .en(en),
		.rem_in({15'd0, mag_x_s2[19:15]}),
		.dvd_in({mag_x_s2[14:0], 16'd0}),
		.dvs_in(fx_eff),
		.quo(qn_x)
	);

	fra_pipe_div #(.QW(NDIV_QW), .DW(CFG_W)) u_div_ny (
		.clk(clk), .en(en),
		.rem_in({15'd0, mag_y_s2[19:15]}),
		.dvd_in({mag_y_s2[14:0], 16'd0}),
		.dvs_in(fy_eff),
		.quo(qn_y)
	);

	// |n| kept until the direction divide
	logic [31:0] nmx_s [S_NM:S_R];
	logic [31:0] nmy_s [S_NM:S_R];
	logic [63:0] sqx_s35, sqy_s35, sum_s36;

	always_ff @(posedge clk) begin
		if (en) begin
			nmx_s[S_NM] <= side_s[S_NQ].sat_x ? 32'h8000_0000 : {1'b0, qn_x};
			nmy_s[S_NM] <= side_s[S_NQ].sat_y ? 32'h8000_0000 : {1'b0, qn_y};
			for (int k = S_NM + 1; k <= S_R; k++) begin
				nmx_s[k] <= nmx_s[k-1];
				nmy_s[k] <= nmy_s[k-1];
			end
			sqx_s35 <= 64'(nmx_s[S_NM]) * 64'(nmx_s[S_NM]);
			sqy_s35 <= 64'(nmy_s[S_NM]) * 64'(nmy_s[S_NM]);
			sum_s36 <= sqx_s35 + sqy_s35;
		end
	end

	// radius: one result bit per pass of the square root, two input bits consumed per pass, one pass per stage
	sq_t         sq_in;
	sq_t         sq_s [1:SQ_N];
	logic [31:0] r_c;

	assign sq_in = '{val: sum_s36, rem: '0, root: '0};
	assign r_c = sq_s[SQ_N].root;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[1] <= sq_step(sq_in);
			for (int k = 2; k <= SQ_N; k++) begin
				sq_s[k] <= sq_step(sq_s[k-1]);
			end
		end
	end

	// theta = atan(r / 65536) by CORDIC vectoring
	cd_t cd_in;
	cd_t cd_s [1:CORDIC_N];

	assign cd_in = '{x: 36'sd65536, y: $signed({4'd0, r_c}), z: '0};

	always_ff @(posedge clk) begin
		if (en) begin
			cd_s[1] <= cd_step(cd_in, 4'd0);
			for (int k = 2; k <= CORDIC_N; k++) begin
				cd_s[k] <= cd_step(cd_s[k-1], 4'(k - 1));
			end
		end
	end

	// direction cosines |n| * 65536 / r, at most 65536
	logic [UDIV_QW-1:0] qu_x, qu_y;

	fra_pipe_div #(.QW(UDIV_QW), .DW(32)) u_div_ux (
		.clk(clk), .en(en),
		.rem_in({1'b0, nmx_s[S_R][31:1]}),
		.dvd_in({nmx_s[S_R][0], 16'd0}),
		.dvs_in(r_c),
		.quo(qu_x)
	);

	fra_pipe_div #(.QW(UDIV_QW), .DW(32)) u_div_uy (
		.clk(clk), .en(en),
		.rem_in({1'b0, nmy_s[S_R][31:1]}),
		.dvd_in({nmy_s[S_R][0], 16'd0}),
		.dvs_in(r_c),
		.quo(qu_y)
	);

	// zero radius flag runs alongside
	logic rz_s [S_R+1:S_M];

	always_ff @(posedge clk) begin
		if (en) begin
			rz_s[S_R+1] <= (r_c == '0);
			for (int k = S_R + 2; k <= S_M; k++) begin
				rz_s[k] <= rz_s[k-1];
			end
		end
	end

	// polynomial in theta
	logic [16:0]        th_s [S_TH:S_POLY];
	logic signed [17:0] u_x_s [S_UQ+1:S_THD];
	logic signed [17:0] u_y_s [S_UQ+1:S_THD];
	logic signed [17:0] uqx_c, uqy_c;
	logic [33:0]        t2_prod;
	logic [35:0]        t4_prod;
	logic [37:0]        t6_prod;
	logic [39:0]        t8_prod;
	logic [17:0]        t2_s86, t2_s87, t2_s88;
	logic [19:0]        t4_s87, t4_s88;
	logic [21:0]        t6_s88;
	logic [23:0]        t8_s88;
	logic signed [44:0] p2_s89, p4_s89, p6_s89, p8_s89;
	logic signed [46:0] acc_s90;
	logic signed [46:0] acc_sh;
	logic signed [31:0] poly_s91;

	assign uqx_c = $signed({1'b0, qu_x});
	assign uqy_c = $signed({1'b0, qu_y});
	assign t2_prod = 34'(th_s[S_TH]) * 34'(th_s[S_TH]);
	assign t4_prod = 36'(t2_s86) * 36'(t2_s86);
	assign t6_prod = 38'(t4_s87) * 38'(t2_s87);
	assign t8_prod = 40'(t4_s87) * 40'(t4_s87);
	assign acc_sh = acc_s90 >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			th_s[S_TH] <= cd_s[CORDIC_N].z[19] ? 17'd0 : cd_s[CORDIC_N].z[16:0];
			for (int k = S_TH + 1; k <= S_POLY; k++) begin
				th_s[k] <= th_s[k-1];
			end
			u_x_s[S_UQ+1] <= side_s[S_UQ].neg_x ? -uqx_c : uqx_c;
			u_y_s[S_UQ+1] <= side_s[S_UQ].neg_y ? -uqy_c : uqy_c;
			for (int k = S_UQ + 2; k <= S_THD; k++) begin
				u_x_s[k] <= u_x_s[k-1];
				u_y_s[k] <= u_y_s[k-1];
			end
			t2_s86 <= t2_prod[33:16];
			t4_s87 <= t4_prod[35:16];
			t2_s87 <= t2_s86;
			t6_s88 <= t6_prod[37:16];
			t8_s88 <= t8_prod[39:16];
			t2_s88 <= t2_s87;
			t4_s88 <= t4_s87;
			p2_s89 <= 45'(coef_t2_q) * 45'($signed({1'b0, t2_s88}));
			p4_s89 <= 45'(coef_t4_q) * 45'($signed({1'b0, t4_s88}));
			p6_s89 <= 45'(coef_t6_q) * 45'($signed({1'b0, t6_s88}));
			p8_s89 <= 45'(coef_t8_q) * 45'($signed({1'b0, t8_s88}));
			acc_s90 <= 47'(p2_s89) + 47'(p4_s89) + 47'(p6_s89) + 47'(p8_s89);
			poly_s91 <= 32'(acc_sh) + 32'sd65536;
		end
	end

	// distorted radius, scale along direction, back to pixels
	logic signed [49:0] thd_prod;
	logic signed [33:0] thd_s92;
	logic signed [51:0] mx_prod, my_prod;
	logic signed [35:0] mx_s93, my_s93;
	logic signed [56:0] ox_prod, oy_prod;
	logic signed [40:0] offx_s94, offy_s94;
	logic signed [41:0] scx_s95, scy_s95;

	assign thd_prod = 50'($signed({1'b0, th_s[S_POLY]})) * 50'(poly_s91);
	assign mx_prod = 52'(thd_s92) * 52'(u_x_s[S_THD]);
	assign my_prod = 52'(thd_s92) * 52'(u_y_s[S_THD]);
	assign ox_prod = 57'(mx_s93) * 57'($signed({1'b0, fx_eff}));
	assign oy_prod = 57'(my_s93) * 57'($signed({1'b0, fy_eff}));

	always_ff @(posedge clk) begin
		if (en) begin
			thd_s92 <= thd_prod[49:16];
			mx_s93 <= mx_prod[51:16];
			my_s93 <= my_prod[51:16];
			offx_s94 <= rz_s[S_M] ? '0 : ox_prod[56:16];
			offy_s94 <= rz_s[S_M] ? '0 : oy_prod[56:16];
			scx_s95 <= 42'(offx_s94) + 42'($signed({1'b0, center_x_q}));
			scy_s95 <= 42'(offy_s94) + 42'($signed({1'b0, center_y_q}));
		end
	end

	// truncate toward zero: bias negatives by 255 before the shift
	logic signed [41:0] bx, by;
	logic [33:0]        trx, try_c;
	logic               ok_c;
	logic [9:0]         out_x_s96;
	logic [8:0]         out_y_s96;
	logic               out_flag_s96;

	assign bx = scx_s95 + $signed({34'd0, {8{scx_s95[41]}}});
	assign by = scy_s95 + $signed({34'd0, {8{scy_s95[41]}}});
	assign trx = bx[41:8];
	assign try_c = by[41:8];
	assign ok_c = !trx[33] && (trx < 34'(IMAGE_WIDTH)) &&
		!try_c[33] && (try_c < 34'(IMAGE_HEIGHT));

	always_ff @(posedge clk) begin
		if (en) begin
			out_x_s96 <= ok_c ? trx[9:0] : side_s[S_OUT-1].px;
			out_y_s96 <= ok_c ? try_c[8:0] : side_s[S_OUT-1].py;
			out_flag_s96 <= ok_c;
		end
	end

	assign m_axis_tdata = {5'd0, out_y_s96, out_x_s96};
	assign m_axis_tuser = out_flag_s96;

endmodule

>>> tb/sv/fisheye_remap_address_tb.sv
// fisheye_remap_address_tb: self-checking bench for the fisheye remap address block.
// Drives pixel words with random gaps and stalls, predicts each source address in place.
// Depends on fra_pkg and fisheye_remap_address.
`timescale 1ns / 1ps

module fisheye_remap_address_tb;
	import fra_pkg::*;

	localparam int WIDTH     = 640;
	localparam int HEIGHT    = 480;
	localparam int LATENCY   = 96;
	localparam int WDOG_MAX  = 20000;
	localparam longint NSAT  = 64'sd2147483648;

	typedef struct packed {
		logic [9:0] sx;
		logic [8:0] sy;
		logic       hit;
	} src_addr_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	logic [CFG_W-1:0] regs [8];
	src_addr_t addr_q [$];
	int errors = 0;
	int words_in = 0;
	int words_out = 0;
	int hits = 0;
	int idle_cycles = 0;
	bit stall_rx = 1'b0;

	fisheye_remap_address #(.IMAGE_WIDTH(WIDTH), .IMAGE_HEIGHT(HEIGHT)) uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint norm_offset(longint d, longint f);
		longint q;
		if (f == 0) f = 1;
		q = (d * 65536) / f;
		if (q > NSAT) q = NSAT;
		if (q < -NSAT) q = -NSAT;
		return q;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint atan_q16(longint r);
		longint x, y, z, nx;
		x = 65536;
		y = r;
		z = 0;
		for (int i = 0; i < CORDIC_N; i++) begin
			if (y >= 0) begin
				nx = x + asr(y, i);
				y = y - asr(x, i);
				z += longint'(ATAN_TAB[i]);
			end else begin
				nx = x - asr(y, i);
				y = y + asr(x, i);
				z -= longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		return z < 0 ? 0 : z;
	endfunction

	function automatic longint coef(int i);
		return longint'(signed'(regs[i]));
	endfunction

	function automatic longint to_pixel(longint v);
		return v >= 0 ? (v >> 8) : -((-v) >> 8);
	endfunction

	function automatic src_addr_t remap_pixel(logic [9:0] px, logic [8:0] py);
		longint fx, fy, cx, cy, nx, ny, r, th, t2, t4, t6, t8, acc, poly, thd;
		longint offx, offy, sx, sy;
		longint unsigned ax, ay;
		src_addr_t a;
		fx = regs[REG_FOCAL_X] == 0 ? 1 : longint'(regs[REG_FOCAL_X]);
		fy = regs[REG_FOCAL_Y] == 0 ? 1 : longint'(regs[REG_FOCAL_Y]);
		cx = longint'(regs[REG_CENTER_X]);
		cy = longint'(regs[REG_CENTER_Y]);
		nx = norm_offset(longint'(px) * 256 - cx, fx);
		ny = norm_offset(longint'(py) * 256 - cy, fy);
		ax = nx < 0 ? -nx : nx;
		ay = ny < 0 ? -ny : ny;
		r = int_sqrt(ax * ax + ay * ay);
		offx = 0;
		offy = 0;
		if (r > 0) begin
			th = atan_q16(r);
			t2 = (th * th) >> 16;
			t4 = (t2 * t2) >> 16;
			t6 = (t4 * t2) >> 16;
			t8 = (t4 * t4) >> 16;
			acc = coef(REG_COEF_T2) * t2 + coef(REG_COEF_T4) * t4
				+ coef(REG_COEF_T6) * t6 + coef(REG_COEF_T8) * t8;
			poly = 65536 + asr(acc, 16);
			thd = asr(th * poly, 16);
			offx = asr(asr(thd * ((nx * 65536) / r), 16) * fx, 16);
			offy = asr(asr(thd * ((ny * 65536) / r), 16) * fy, 16);
		end
		sx = to_pixel(offx + cx);
		sy = to_pixel(offy + cy);
		if (sx >= 0 && sx < WIDTH && sy >= 0 && sy < HEIGHT) begin
			a.sx = sx[9:0];
			a.sy = sy[8:0];
			a.hit = 1'b1;
		end else begin
			a.sx = px;
			a.sy = py;
			a.hit = 1'b0;
		end
		return a;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch at result %0d: %s got %0d want %0d", words_out, what, got, want);
		errors++;
	endtask

	// output side: random stall per word, compare against oldest prediction
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (addr_q.size() == 0) begin
				report("unexpected word", m_axis_tdata, 0);
			end else begin
				src_addr_t w;
				w = addr_q.pop_front();
				if (m_axis_tdata[9:0] !== w.sx) report("source_x", m_axis_tdata[9:0], w.sx);
				if (m_axis_tdata[18:10] !== w.sy) report("source_y", m_axis_tdata[18:10], w.sy);
				if (m_axis_tdata[23:19] !== 5'd0) report("pad", m_axis_tdata[23:19], 0);
				if (m_axis_tuser !== w.hit) report("remapped", m_axis_tuser, w.hit);
				if (w.hit) hits++;
			end
			words_out++;
		end
	end

	initial begin : rx_side
		int n;
		@(posedge arst_n);
		forever begin
			n = stall_rx ? $urandom_range(0, 11) : 0;
			if (n == 0) begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// watchdog: cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("watchdog expired, %0d words still pending", addr_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_pixel(logic [9:0] px, logic [8:0] py, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, py, px};
		addr_q.push_back(remap_pixel(px, py));
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_in++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (addr_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	// leaves cfg_we high; the caller drops it after the last write
	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		regs[idx] = val;
		@(posedge clk);
	endtask

	task automatic load_lens(logic [CFG_W-1:0] fx, logic [CFG_W-1:0] fy, logic [CFG_W-1:0] cx,
			logic [CFG_W-1:0] cy, logic [CFG_W-1:0] k1, logic [CFG_W-1:0] k2,
			logic [CFG_W-1:0] k3, logic [CFG_W-1:0] k4);
		write_reg(REG_FOCAL_X, fx);
		write_reg(REG_FOCAL_Y, fy);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_COEF_T2, k1);
		write_reg(REG_COEF_T4, k2);
		write_reg(REG_COEF_T6, k3);
		write_reg(REG_COEF_T8, k4);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed();
		// corners, center (zero radius), max field codes beyond the image
		send_pixel(10'd0, 9'd0, 0);
		send_pixel(10'd639, 9'd0, 0);
		send_pixel(10'd0, 9'd479, 0);
		send_pixel(10'd639, 9'd479, 0);
		send_pixel(10'd320, 9'd240, 0);
		send_pixel(10'd1023, 9'd511, 0);
		send_pixel(10'd1023, 9'd0, 1);
		send_pixel(10'd0, 9'd511, 1);
		send_pixel(10'd321, 9'd241, 1);
		send_pixel(10'd319, 9'd239, 1);
		drain();
		// strong barrel distortion, then zero focal and huge offsets
		load_lens(20'd60000, 20'd60000, 20'd81920, 20'd61440,
			20'hF0000, 20'h02000, 20'hFF000, 20'h00100);
		send_pixel(10'd0, 9'd0, 0);
		send_pixel(10'd639, 9'd479, 0);
		send_pixel(10'd500, 9'd100, 0);
		drain();
		load_lens(20'd0, 20'd0, 20'd0, 20'd0, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000);
		send_pixel(10'd0, 9'd0, 0);
		send_pixel(10'd1023, 9'd511, 0);
		send_pixel(10'd1, 9'd1, 0);
		drain();
		load_lens(20'hFFFFF, 20'd256, 20'hFFFFF, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'h80000,
			20'h7FFFF);
		send_pixel(10'd0, 9'd0, 0);
		send_pixel(10'd639, 9'd479, 0);
		send_pixel(10'd1023, 9'd511, 0);
		drain();
	endtask

	task automatic test_random(int n_sets, int per_set);
		logic [CFG_W-1:0] c [4];
		for (int s = 0; s < n_sets; s++) begin
			// mostly plausible lenses with small coefficients, some raw register noise
			for (int k = 0; k < 4; k++)
				c[k] = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom())
					: CFG_W'(signed'(CFG_W'($urandom_range(0, 16384))) - 20'sd8192);
			if ($urandom_range(0, 4) == 0)
				load_lens(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
					CFG_W'($urandom()), c[0], c[1], c[2], c[3]);
			else
				load_lens(CFG_W'($urandom_range(20000, 200000)),
					CFG_W'($urandom_range(20000, 200000)),
					CFG_W'($urandom_range(60000, 104000)), CFG_W'($urandom_range(40000, 82000)),
					c[0], c[1], c[2], c[3]);
			stall_rx = (s % 3) != 0;
			for (int i = 0; i < per_set; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_pixel(10'($urandom()), 9'($urandom()), stall_rx);
				else
					send_pixel(10'($urandom_range(0, WIDTH - 1)),
						9'($urandom_range(0, HEIGHT - 1)), stall_rx);
			end
			drain();
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++) regs[i] = '0;
		regs[REG_FOCAL_X] = FOCAL_X_RST;
		regs[REG_FOCAL_Y] = FOCAL_Y_RST;
		regs[REG_CENTER_X] = CENTER_X_RST;
		regs[REG_CENTER_Y] = CENTER_Y_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(12, 150);
		$display("sent %0d pixel words, checked %0d results, %0d inside the image",
			words_in, words_out, hits);
		$display("covered 16 register settings including zero focal and extreme coefficients");
		if (errors == 0 && addr_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
